@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

@@ rtl/core/lgsb_pkg.sv @@
// ----------------------------------------------------------------------------
// lgsb_pkg
// Sizes, codes, controller command type and address helpers of the LED
// grayscale scan buffer.
// ----------------------------------------------------------------------------
package lgsb_pkg;

  localparam int CHIP_COUNT         = 2;
  localparam int ROW_COUNT          = 4;
  localparam int CHANNELS_PER_COLOR = 8;

  localparam int SLOTS_PER_CHIP = 3 * CHANNELS_PER_COLOR;
  localparam int WORDS_PER_ROW  = CHIP_COUNT * SLOTS_PER_CHIP;
  localparam int WORDS_PER_BUF  = ROW_COUNT * WORDS_PER_ROW;
  localparam int TOTAL_WORDS    = 2 * WORDS_PER_BUF;
  localparam int FIRST_OFFSET   = (CHIP_COUNT - 1) * SLOTS_PER_CHIP;

  localparam int ADDR_W = $clog2(TOTAL_WORDS);
  localparam int SROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  localparam int CMD_W   = 3;
  localparam int CHIP_W  = 3;
  localparam int COLOR_W = 2;
  localparam int CHAN_W  = 4;
  localparam int ROW_W   = 3;
  localparam int GRAY_W  = 12;
  localparam int RSEL_W  = 4;
  localparam int MODE_W  = 2;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHAIN = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_RED = 2'd2;

  localparam logic CFG_REG_CHAIN_MODE = 1'b0;

  typedef struct packed {
    logic              acc_write;
    logic              acc_read;
    logic              swap;
    logic              tick;
    logic              tick_null;
    logic              fill_latch;
    logic              sweep_wr;
    logic              sweep_clear;
    logic              stream_rd;
    logic              stream_last;
    logic [ADDR_W-1:0] idx;
  } lgsb_cmd_t;

  function automatic logic [ADDR_W-1:0] word_addr(input logic buf_sel, input int r,
                                                   input int chip, input int lane,
                                                   input int channel);
    int a;
    a = int'(buf_sel) * WORDS_PER_BUF + r * WORDS_PER_ROW
      + (CHIP_COUNT - 1 - chip) * SLOTS_PER_CHIP
      + (CHANNELS_PER_COLOR - 1 - channel) * 3 + lane;
    return ADDR_W'(a);
  endfunction

  function automatic logic [RSEL_W-1:0] row_enables(input logic [SROW_W-1:0] r);
    return (int'(r) < RSEL_W) ? (RSEL_W'(1) << r) : '0;
  endfunction

  function automatic logic [SROW_W-1:0] row_wrap_inc(input logic [SROW_W-1:0] r);
    return (int'(r) == ROW_COUNT - 1) ? '0 : SROW_W'(r + SROW_W'(1));
  endfunction

endpackage

@@ rtl/core/lgsb_ram.sv @@
// ----------------------------------------------------------------------------
// lgsb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lgsb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/lgsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// lgsb_ctrl
// Request decoder and sequencer: clearing pass after reset, back-buffer fill
// sweep and row streaming, issued to the datapath as commands.
// ----------------------------------------------------------------------------
module lgsb_ctrl import lgsb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [MODE_W-1:0] chain_mode,
  output logic              busy,
  output lgsb_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_STREAM
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep_wr    = 1'b1;
        cmd.sweep_clear = 1'b1;
        cmd.idx         = cnt_r;
        if (cnt_r == ADDR_W'(TOTAL_WORDS - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            CMD_WRITE: cmd.acc_write = 1'b1;
            CMD_READ:  cmd.acc_read  = 1'b1;
            CMD_SWAP:  cmd.swap      = 1'b1;
            CMD_FILL: begin
              cmd.fill_latch = 1'b1;
              state_nxt      = ST_FILL;
              cnt_nxt        = '0;
            end
            CMD_TICK: begin
              cmd.tick = 1'b1;
              priority if (chain_mode == MODE_CHAIN) begin
                state_nxt = ST_STREAM;
                cnt_nxt   = '0;
              end else if (chain_mode == MODE_FIRST) begin
                state_nxt = ST_STREAM;
                cnt_nxt   = ADDR_W'(FIRST_OFFSET);
              end else begin
                cmd.tick_null = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        cmd.sweep_wr = 1'b1;
        cmd.idx      = cnt_r;
        if (cnt_r == ADDR_W'(WORDS_PER_BUF - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_STREAM: begin
        cmd.stream_rd = 1'b1;
        cmd.idx       = cnt_r;
        if (cnt_r == ADDR_W'(WORDS_PER_ROW - 1)) begin
          cmd.stream_last = 1'b1;
          state_nxt       = ST_IDLE;
          cnt_nxt         = '0;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ rtl/core/lgsb_dpath.sv @@
// ----------------------------------------------------------------------------
// lgsb_dpath
// Frame store, buffer and row state, address generation and the two-stage
// result pipeline.
// ----------------------------------------------------------------------------
module lgsb_dpath import lgsb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lgsb_cmd_t          cmd,
  input  logic [CHIP_W-1:0]  in_chip,
  input  logic [COLOR_W-1:0] in_color,
  input  logic [CHAN_W-1:0]  in_channel,
  input  logic [ROW_W-1:0]   in_row,
  input  logic [GRAY_W-1:0]  in_value,
  output logic               out_valid,
  output logic               out_kind,
  output logic [GRAY_W-1:0]  out_data,
  output logic [RSEL_W-1:0]  out_row_select,
  output logic               out_word_valid,
  output logic               out_last
);

  logic              front_r;
  logic [SROW_W-1:0] scan_row_r, scan_row_nxt;
  logic [ADDR_W-1:0] base_r;
  logic [GRAY_W-1:0] fill_val_r;

  logic              p1_valid_r;
  logic              p1_kind_r;
  logic              p1_zero_r;
  logic              p1_wv_r;
  logic              p1_last_r;
  logic [RSEL_W-1:0] p1_rsel_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [GRAY_W-1:0] out_data_r;
  logic [RSEL_W-1:0] out_rsel_r;
  logic              out_wv_r;
  logic              out_last_r;

  logic               back;
  logic [COLOR_W-1:0] lane;
  logic               chip_ok;
  logic               chan_ok;
  logic               row_ok;
  logic [ADDR_W-1:0]  wr_addr_acc;
  logic [ADDR_W-1:0]  rd_addr_acc;
  logic [ADDR_W-1:0]  back_base;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [GRAY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [GRAY_W-1:0] ram_rdata;

  assign back    = ~front_r;
  assign lane    = (in_color <= COLOR_RED) ? in_color : '0;
  assign chip_ok = (int'(in_chip) < CHIP_COUNT);
  assign chan_ok = (int'(in_channel) < CHANNELS_PER_COLOR);
  assign row_ok  = (int'(in_row) < ROW_COUNT);

  assign wr_addr_acc = word_addr(back, int'(in_row), int'(in_chip), int'(lane),
                                 int'(in_channel));
  assign rd_addr_acc = word_addr(back, int'(scan_row_r), int'(in_chip), int'(lane),
                                 int'(in_channel));
  assign back_base   = ADDR_W'(int'(back) * WORDS_PER_BUF);

  assign scan_row_nxt = cmd.tick ? row_wrap_inc(scan_row_r) : scan_row_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_acc;
    ram_wdata = in_value;
    if (cmd.sweep_wr) begin
      ram_we = 1'b1;
      if (cmd.sweep_clear) begin
        ram_waddr = cmd.idx;
        ram_wdata = '0;
      end else begin
        ram_waddr = back_base + cmd.idx;
        ram_wdata = fill_val_r;
      end
    end else if (cmd.acc_write) begin
      ram_we = chip_ok && chan_ok && row_ok;
    end
  end

  assign ram_re    = cmd.acc_read || cmd.stream_rd;
  assign ram_raddr = cmd.stream_rd ? (base_r + cmd.idx) : rd_addr_acc;

  lgsb_ram #(
    .WIDTH (GRAY_W),
    .DEPTH (TOTAL_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= 1'b0;
      scan_row_r  <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.swap) begin
        front_r <= back;
      end
      scan_row_r  <= scan_row_nxt;
      p1_valid_r  <= cmd.acc_read || cmd.stream_rd || cmd.tick_null;
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      base_r <= ADDR_W'(int'(front_r) * WORDS_PER_BUF
                        + int'(row_wrap_inc(scan_row_nxt)) * WORDS_PER_ROW);
    end
    if (cmd.fill_latch) begin
      fill_val_r <= in_value;
    end
    p1_kind_r  <= !cmd.acc_read;
    p1_zero_r  <= (cmd.acc_read && !(chip_ok && chan_ok)) || cmd.tick_null;
    p1_wv_r    <= !cmd.tick_null;
    p1_last_r  <= cmd.acc_read || cmd.tick_null || cmd.stream_last;
    p1_rsel_r  <= row_enables(scan_row_nxt);
    out_kind_r <= p1_kind_r;
    out_data_r <= p1_zero_r ? '0 : ram_rdata;
    out_rsel_r <= p1_rsel_r;
    out_wv_r   <= p1_wv_r;
    out_last_r <= p1_last_r;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data       = out_data_r;
  assign out_row_select = out_rsel_r;
  assign out_word_valid = out_wv_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/core/led_grayscale_scan_buffer.sv @@
// ----------------------------------------------------------------------------
// led_grayscale_scan_buffer
// Double-buffered 12-bit grayscale store for a row-multiplexed LED driver
// chain, with register port and scan streaming.
// ----------------------------------------------------------------------------
// Requests enter on start with the in_ ports and are taken when busy is low.
// Results leave on the out_ ports for one cycle each, marked by out_valid;
// the receiver cannot stall them, so it must take every word as it comes.
// Write and swap are done as they are taken, with busy staying low. A read
// reply passes the frame store's read register and then the output register.
// A fill sweeps all 192 words of the back buffer one word a cycle, with busy
// high. A scan tick streams front-buffer words one a cycle, with busy high,
// through the same registers: 48 for the whole chain, 24 for the first
// driver only, and a single null result with no driver. The streaming rate
// is set by the single read port of the frame store. Reset clears all 384
// words of the frame store, one word a cycle, with busy high; register
// writes are still taken. chain_mode resets to the whole chain and lies at
// byte address 0 of the register port.
module led_grayscale_scan_buffer import lgsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [CHIP_W-1:0]     in_chip,
  input  logic [COLOR_W-1:0]    in_color,
  input  logic [CHAN_W-1:0]     in_channel,
  input  logic [ROW_W-1:0]      in_row,
  input  logic [GRAY_W-1:0]     in_value,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic [GRAY_W-1:0]     out_data,
  output logic [RSEL_W-1:0]     out_row_select,
  output logic                  out_word_valid,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [MODE_W-1:0] chain_mode_r;
  logic              cfg_wr;
  lgsb_cmd_t         cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_mode_r <= MODE_CHAIN;
    end else if (cfg_wr && (paddr[2] == CFG_REG_CHAIN_MODE)) begin
      chain_mode_r <= pwdata[MODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_REG_CHAIN_MODE) ? CFG_DATA_W'(chain_mode_r) : '0;

  lgsb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_cmd     (in_cmd),
    .chain_mode (chain_mode_r),
    .busy       (busy),
    .cmd        (cmd)
  );

  lgsb_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_chip        (in_chip),
    .in_color       (in_color),
    .in_channel     (in_channel),
    .in_row         (in_row),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_data       (out_data),
    .out_row_select (out_row_select),
    .out_word_valid (out_word_valid),
    .out_last       (out_last)
  );

endmodule

@@ rtl/core/lgsb_checker.sv @@
// ----------------------------------------------------------------------------
// lgsb_checker
// Port-level checks of the LED grayscale scan buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lgsb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_kind,
  input logic [11:0] out_data,
  input logic [3:0]  out_row_select,
  input logic        out_word_valid,
  input logic        out_last
);

  `ASSERT_NEXT(a_stream_contiguous, clk, rst_n, out_valid && !out_last, out_valid)
  `ASSERT_IMP(a_read_single, clk, rst_n, out_valid && !out_kind, out_last && out_word_valid)
  `ASSERT_IMP(a_null_word, clk, rst_n, out_valid && !out_word_valid, out_kind && out_last && (out_data == 12'd0))
  `ASSERT_IMP(a_row_onehot, clk, rst_n, out_valid, $onehot0(out_row_select))
  `ASSERT_IMP(a_clear_after_reset, clk, rst_n, $past(!rst_n), busy && !out_valid)

endmodule

bind led_grayscale_scan_buffer lgsb_checker u_lgsb_checker (.*);
